FILE: rtl/rpip_pkg.sv
// Shared types and character constants for the radix-prefixed integer parser.
// No dependencies.
package rpip_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_UC_B  = 8'h42;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;

  localparam int unsigned VALUE_W = 64;

  // Classified character word passed from front to back.
  typedef struct packed {
    logic       present;
    logic       last;
    logic       is_space;
    logic       is_bmark;
    logic       is_xmark;
    logic       is_digit;
    logic [3:0] digit;
  } cls_t;

endpackage

FILE: rtl/rpip_queue.sv
// Short FIFO of classified character words between front and back.
// Depends on rpip_pkg.
module rpip_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  rpip_pkg::cls_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output rpip_pkg::cls_t rd_data
);
  import rpip_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cls_t             store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == FULL_CNT);
  assign rd_valid = (count != '0);
  assign rd_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/rpip_front.sv
// Input side: takes character words, drops empty ones and classifies the rest.
// Depends on rpip_pkg; feeds rpip_queue.
module rpip_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    char_code,
  input  logic          char_present,
  input  logic          end_of_string,
  input  logic          q_full,
  output logic          q_wr_en,
  output rpip_pkg::cls_t q_wr_data
);
  import rpip_pkg::*;

  logic is_dec;
  logic is_lc;
  logic is_uc;

  assign in_stall = q_full;
  // a word with neither a character nor an end mark does nothing
  assign q_wr_en  = in_valid && !q_full && (char_present || end_of_string);

  always_comb begin
    is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_lc  = (char_code >= CH_LC_A) && (char_code <= CH_LC_F);
    is_uc  = (char_code >= CH_UC_A) && (char_code <= CH_UC_F);

    q_wr_data.present  = char_present;
    q_wr_data.last     = end_of_string;
    q_wr_data.is_space = (char_code == CH_SPACE) ||
                         ((char_code >= CH_TAB) && (char_code <= CH_CR));
    q_wr_data.is_bmark = (char_code == CH_LC_B) || (char_code == CH_UC_B);
    q_wr_data.is_xmark = (char_code == CH_LC_X) || (char_code == CH_UC_X);
    q_wr_data.is_digit = is_dec || is_lc || is_uc;
    if (is_dec) begin
      q_wr_data.digit = 4'(char_code - CH_ZERO);
    end else if (is_lc) begin
      q_wr_data.digit = 4'(char_code - CH_LC_A + 8'd10);
    end else if (is_uc) begin
      q_wr_data.digit = 4'(char_code - CH_UC_A + 8'd10);
    end else begin
      q_wr_data.digit = 4'd0;
    end
  end

endmodule

FILE: rtl/rpip_back.sv
// Parse engine: prefix/phase tracking, saturating shift-add accumulator and
// the registered result stage. Depends on rpip_pkg; reads from rpip_queue.
module rpip_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rpip_pkg::cls_t q_data,
  output logic          q_rd_en,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [rpip_pkg::VALUE_W-1:0] parsed_value,
  output logic          parse_ok
);
  import rpip_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_ZERO,
    PH_RUN,
    PH_TRAIL
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_BIN,
    RX_OCT,
    RX_HEX
  } radix_t;

  localparam int unsigned WIDE_W = VALUE_W + 4;

  phase_t             phase, phase_next;
  radix_t             radix, radix_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               err, err_next;

  radix_t             rx_use;
  logic               dig_ok;
  logic               take_digit;
  logic [WIDE_W-1:0]  acc_wide;
  logic [WIDE_W-1:0]  prod;
  logic [VALUE_W-1:0] mac;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  // an end word has to wait for the result register; others go straight on
  assign q_rd_en  = q_valid && (!q_data.last || out_free);

  // saturating acc * base + digit
  always_comb begin
    acc_wide = {4'd0, acc};
    case (rx_use)
      RX_BIN:  prod = acc_wide << 1;
      RX_OCT:  prod = acc_wide << 3;
      RX_HEX:  prod = acc_wide << 4;
      default: prod = (acc_wide << 3) + (acc_wide << 1);
    endcase
    prod = prod + {{(WIDE_W-4){1'b0}}, q_data.digit};
    mac  = (prod[WIDE_W-1:VALUE_W] != 4'd0) ? '1 : prod[VALUE_W-1:0];
  end

  always_comb begin
    case (phase)
      PH_LEAD: rx_use = RX_DEC;
      PH_ZERO: rx_use = RX_OCT;
      default: rx_use = radix;
    endcase
    case (rx_use)
      RX_BIN:  dig_ok = q_data.is_digit && (q_data.digit <= 4'd1);
      RX_OCT:  dig_ok = q_data.is_digit && (q_data.digit <= 4'd7);
      RX_HEX:  dig_ok = q_data.is_digit;
      default: dig_ok = q_data.is_digit && (q_data.digit <= 4'd9);
    endcase
  end

  always_comb begin
    phase_next = phase;
    radix_next = radix;
    err_next   = err;
    take_digit = 1'b0;
    if (q_data.present && !err) begin
      unique case (phase)
        PH_LEAD: begin
          if (q_data.is_space) begin
            phase_next = PH_LEAD;
          end else if (q_data.is_digit && (q_data.digit == 4'd0)) begin
            phase_next = PH_ZERO;
            radix_next = RX_OCT;
          end else begin
            radix_next = RX_DEC;
            if (dig_ok) begin
              take_digit = 1'b1;
              phase_next = PH_RUN;
            end else begin
              err_next = 1'b1;
            end
          end
        end
        PH_ZERO: begin
          if (q_data.is_bmark) begin
            radix_next = RX_BIN;
            phase_next = PH_RUN;
          end else if (q_data.is_xmark) begin
            radix_next = RX_HEX;
            phase_next = PH_RUN;
          end else if (q_data.is_space) begin
            phase_next = PH_TRAIL;
          end else if (dig_ok) begin
            take_digit = 1'b1;
            phase_next = PH_RUN;
          end else begin
            err_next = 1'b1;
          end
        end
        PH_RUN: begin
          if (q_data.is_space) begin
            phase_next = PH_TRAIL;
          end else if (dig_ok) begin
            take_digit = 1'b1;
          end else begin
            err_next = 1'b1;
          end
        end
        default: begin
          if (!q_data.is_space) begin
            err_next = 1'b1;
          end
        end
      endcase
    end
    acc_next = take_digit ? mac : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEAD;
      radix     <= RX_DEC;
      acc       <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_rd_en && q_data.last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_rd_en) begin
        if (q_data.last) begin
          parsed_value <= err_next ? '0 : acc_next;
          parse_ok     <= !err_next;
          phase        <= PH_LEAD;
          radix        <= RX_DEC;
          acc          <= '0;
          err          <= 1'b0;
        end else begin
          phase <= phase_next;
          radix <= radix_next;
          acc   <= acc_next;
          err   <= err_next;
        end
      end
    end
  end

endmodule

FILE: rtl/radix_prefixed_integer_parser.sv
// Radix-prefixed integer parser, top level: front classifier, word queue, parse engine.
// Result path: an end word passes through the word queue and then the result register before out_valid rises.
// Throughput: one character word per cycle while in_stall is low; the queue absorbs output stalls until full.
// Reset: synchronous on rst; clears the queue, the parse state and out_valid.
// Depends on rpip_pkg, rpip_front, rpip_queue and rpip_back.
module radix_prefixed_integer_parser #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        char_present,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] parsed_value,
  output logic        parse_ok
);
  import rpip_pkg::*;

  logic q_full;
  logic q_wr_en;
  cls_t q_wr_data;
  logic q_rd_en;
  logic q_valid;
  cls_t q_rd_data;

  rpip_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .char_code     (char_code),
    .char_present  (char_present),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .q_wr_en       (q_wr_en),
    .q_wr_data     (q_wr_data)
  );

  rpip_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr_en),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_en    (q_rd_en),
    .rd_valid (q_valid),
    .rd_data  (q_rd_data)
  );

  rpip_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_rd_data),
    .q_rd_en      (q_rd_en),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .parsed_value (parsed_value),
    .parse_ok     (parse_ok)
  );

endmodule

FILE: rtl/rpip_checker.sv
// Port-level checks for radix_prefixed_integer_parser, attached by bind.
// No package dependencies.
module rpip_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] parsed_value,
  input logic        parse_ok
);

  // reset empties the result register and the queue
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("in_stall set after reset");

  // a failed parse reports zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !parse_ok) |-> (parsed_value == 64'd0))
    else $error("failed parse with non-zero value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(parsed_value) && $stable(parse_ok)))
    else $error("stalled result word changed");

endmodule

bind radix_prefixed_integer_parser rpip_checker u_rpip_checker (.*);
